// ===== hdl/bas_pkg.sv =====
package bas_pkg;

	// Field widths of the configuration port and the result item.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;
	localparam int CODE_W     = 24;
	localparam int TEMP_W     = 12;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXTRA_PULSES  = 3'd5;

	// Register reset values.
	localparam logic [21:0] SCAN_INTERVAL_RST = 22'd200000;
	localparam logic [15:0] POLL_INTERVAL_RST = 16'd1000;
	localparam logic [15:0] READY_TIMEOUT_RST = 16'd1000;
	localparam logic [7:0]  HALF_PERIOD_RST   = 8'd1;
	localparam logic [7:0]  ERROR_LIMIT_RST   = 8'd20;
	localparam logic [1:0]  EXTRA_PULSES_RST  = 2'd2;

	// The temperature is floor(code / 5084) - 1619. The code is first shifted
	// right by two, which leaves a division by 1271 on a 22-bit value. That is
	// done exactly by a multiply with a rounded-up reciprocal and a shift.
	localparam int            RECIP_IN_W = CODE_W - 2;
	localparam int            RECIP_W    = 23;
	localparam logic [22:0]   TEMP_RECIP = 23'd6758407;
	localparam int            TEMP_SHIFT = 33;
	localparam int            PROD_W     = RECIP_IN_W + RECIP_W;
	localparam logic [11:0]   TEMP_OFFSET = 12'd1619;

	localparam logic [7:0]    FAIL_MAX = 8'd255;

	// Sequencer phases.
	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_WAIT  = 6'b000010,
		PH_HIGH  = 6'b000100,
		PH_LOW   = 6'b001000,
		PH_XHIGH = 6'b010000,
		PH_XLOW  = 6'b100000
	} phase_t;

	// Configuration register set.
	typedef struct packed {
		logic [21:0] scan_interval;
		logic [15:0] poll_interval;
		logic [15:0] ready_timeout;
		logic [7:0]  half_period;
		logic [7:0]  error_limit;
		logic [1:0]  extra_pulses;
	} cfg_t;

endpackage

// ===== hdl/bas_in_if.sv =====
interface bas_in_if;
	logic valid;
	logic ready;
	logic data_pin;

	modport source (output valid, output data_pin, input ready);
	modport sink (input valid, input data_pin, output ready);
endinterface

// ===== hdl/bas_out_if.sv =====
interface bas_out_if;
	import bas_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     sck;
	logic                     sample_valid;
	logic [CODE_W-1:0]        raw_code;
	logic signed [TEMP_W-1:0] temperature;
	logic                     read_failed;
	logic                     error_flag;

	modport source (output valid, output sck, output sample_valid, output raw_code,
		output temperature, output read_failed, output error_flag, input ready);
	modport sink (input valid, input sck, input sample_valid, input raw_code,
		input temperature, input read_failed, input error_flag, output ready);
endinterface

// ===== hdl/bas_queue.sv =====
module bas_queue (
	input  logic     clk,
	input  logic     arst_n,
	bas_in_if.sink   wr,
	bas_in_if.source rd
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic             pin_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	// Ready depends only on the fill count, so the input side never waits on
	// the sequencer or the output side combinationally.
	assign wr.ready    = (cnt_q != CNT_W'(DEPTH));
	assign rd.valid    = (cnt_q != '0);
	assign rd.data_pin = pin_q[rd_ptr_q];
	assign push        = wr.valid & wr.ready;
	assign pop         = rd.valid & rd.ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			pin_q[wr_ptr_q] <= wr.data_pin;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== hdl/bas_seq.sv =====
module bas_seq #(
	parameter int DATA_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bas_pkg::CFG_DATA_W-1:0] cfg_data,
	bas_in_if.sink                        ticks,
	bas_out_if.source                     results
);
	import bas_pkg::*;

	localparam int BIT_W = $clog2(DATA_BITS + 1);

	cfg_t                 cfg_q;
	phase_t               phase_q, phase_n;
	logic [21:0]          scan_q, scan_n;
	logic [15:0]          tick_q, tick_n;
	logic [15:0]          poll_q, poll_n;
	logic [BIT_W-1:0]     bit_q, bit_n, bit_inc;
	logic [DATA_BITS-1:0] shift_q, shift_n;
	logic [7:0]           fail_q, fail_n, fail_inc;
	logic                 err_q, err_n;
	logic [CODE_W-1:0]    held_code_q, held_code_n;
	logic [TEMP_W-1:0]    held_temp_q, held_temp_n;
	logic                 sck_q, sck_n;
	logic                 sv_q, sv_n;
	logic                 rf_q, rf_n;
	logic                 out_valid_q;
	logic [PROD_W-1:0]    prod_s1;

	logic                 fire;
	logic                 pin;
	logic                 expired;
	logic                 start;
	logic                 attempt_done;
	logic                 timeout_fail;
	logic [CODE_W-1:0]    code;
	logic                 code_zero;
	logic [TEMP_W-1:0]    temp_calc;

	// Handshake: a tick is taken whenever the output slot is free or drains.
	assign ticks.ready = !out_valid_q || results.ready;
	assign fire        = ticks.valid && ticks.ready;
	assign pin         = ticks.data_pin;

	assign results.valid        = out_valid_q;
	assign results.sck          = sck_q;
	assign results.sample_valid = sv_q;
	assign results.raw_code     = held_code_q;
	assign results.temperature  = held_temp_q;
	assign results.read_failed  = rf_q;
	assign results.error_flag   = err_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_interval <= SCAN_INTERVAL_RST;
			cfg_q.poll_interval <= POLL_INTERVAL_RST;
			cfg_q.ready_timeout <= READY_TIMEOUT_RST;
			cfg_q.half_period   <= HALF_PERIOD_RST;
			cfg_q.error_limit   <= ERROR_LIMIT_RST;
			cfg_q.extra_pulses  <= EXTRA_PULSES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCAN_INTERVAL: cfg_q.scan_interval <= cfg_data[21:0];
				REG_POLL_INTERVAL: cfg_q.poll_interval <= cfg_data[15:0];
				REG_READY_TIMEOUT: cfg_q.ready_timeout <= cfg_data[15:0];
				REG_HALF_PERIOD:   cfg_q.half_period   <= cfg_data[7:0];
				REG_ERROR_LIMIT:   cfg_q.error_limit   <= cfg_data[7:0];
				REG_EXTRA_PULSES:  cfg_q.extra_pulses  <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// The code with its MSB inverted, and its temperature. The shift register
	// settles at least two ticks before an attempt ends, so the registered
	// product always matches it when the result is taken.
	assign code      = CODE_W'(shift_q ^ {1'b1, {(DATA_BITS - 1){1'b0}}});
	assign code_zero = (code == '0);

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(code[CODE_W-1:2]) * PROD_W'(TEMP_RECIP);
	end

	assign temp_calc = prod_s1[TEMP_SHIFT +: TEMP_W] - TEMP_OFFSET;

	assign expired  = (tick_q <= 16'd1);
	assign bit_inc  = bit_q + 1'b1;
	assign fail_inc = (fail_q == FAIL_MAX) ? FAIL_MAX : fail_q + 8'd1;

	// One sequencer step per tick.
	always_comb begin
		phase_n      = phase_q;
		scan_n       = scan_q;
		tick_n       = tick_q;
		poll_n       = poll_q;
		bit_n        = bit_q;
		shift_n      = shift_q;
		fail_n       = fail_q;
		err_n        = err_q;
		held_code_n  = held_code_q;
		held_temp_n  = held_temp_q;
		sck_n        = sck_q;
		sv_n         = 1'b0;
		rf_n         = 1'b0;
		start        = 1'b0;
		attempt_done = 1'b0;
		timeout_fail = 1'b0;

		case (phase_q)
			PH_IDLE: begin
				if (scan_q != '0) begin
					scan_n = scan_q - 22'd1;
				end else begin
					poll_n = '0;
					sck_n  = 1'b0;
					if (!pin) begin
						start = 1'b1;
					end else begin
						tick_n  = cfg_q.poll_interval;
						phase_n = PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				if (!expired) begin
					tick_n = tick_q - 16'd1;
				end else if (poll_q >= cfg_q.ready_timeout) begin
					timeout_fail = 1'b1;
				end else begin
					poll_n = poll_q + 16'd1;
					if (!pin) begin
						start = 1'b1;
					end else begin
						tick_n = cfg_q.poll_interval;
					end
				end
			end
			PH_HIGH, PH_XHIGH: begin
				if (!expired) begin
					tick_n = tick_q - 16'd1;
				end else begin
					sck_n   = 1'b0;
					tick_n  = 16'(cfg_q.half_period);
					phase_n = (phase_q == PH_HIGH) ? PH_LOW : PH_XLOW;
				end
			end
			PH_LOW: begin
				if (!expired) begin
					tick_n = tick_q - 16'd1;
				end else begin
					shift_n = {shift_q[DATA_BITS-2:0], pin};
					sck_n   = 1'b1;
					tick_n  = 16'(cfg_q.half_period);
					if (bit_inc >= BIT_W'(DATA_BITS)) begin
						bit_n   = '0;
						phase_n = PH_XHIGH;
					end else begin
						bit_n   = bit_inc;
						phase_n = PH_HIGH;
					end
				end
			end
			PH_XLOW: begin
				if (!expired) begin
					tick_n = tick_q - 16'd1;
				end else begin
					bit_n = bit_inc;
					if (bit_inc >= BIT_W'(cfg_q.extra_pulses)) begin
						attempt_done = 1'b1;
					end else begin
						sck_n   = 1'b1;
						tick_n  = 16'(cfg_q.half_period);
						phase_n = PH_XHIGH;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		// Converter ready: first rising edge of the serial clock.
		if (start) begin
			sck_n   = 1'b1;
			tick_n  = 16'(cfg_q.half_period);
			bit_n   = '0;
			shift_n = '0;
			phase_n = PH_HIGH;
		end

		// End of an attempt: a nonzero code is a good sample, else a failure.
		if (attempt_done && !code_zero) begin
			held_code_n = code;
			held_temp_n = temp_calc;
			fail_n      = '0;
			sv_n        = 1'b1;
		end
		if (timeout_fail || (attempt_done && code_zero)) begin
			fail_n = fail_inc;
			if (fail_inc > cfg_q.error_limit) begin
				err_n = 1'b1;
			end
			rf_n = 1'b1;
		end
		if (attempt_done || timeout_fail) begin
			sck_n   = 1'b0;
			scan_n  = cfg_q.scan_interval;
			phase_n = PH_IDLE;
		end
	end

	// Sequencer state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			scan_q      <= '0;
			tick_q      <= '0;
			poll_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			fail_q      <= '0;
			err_q       <= 1'b0;
			held_code_q <= '0;
			held_temp_q <= '0;
			sck_q       <= 1'b0;
			sv_q        <= 1'b0;
			rf_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= phase_n;
				scan_q      <= scan_n;
				tick_q      <= tick_n;
				poll_q      <= poll_n;
				bit_q       <= bit_n;
				shift_q     <= shift_n;
				fail_q      <= fail_n;
				err_q       <= err_n;
				held_code_q <= held_code_n;
				held_temp_q <= held_temp_n;
				sck_q       <= sck_n;
				sv_q        <= sv_n;
				rf_q        <= rf_n;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result never reports a good sample and a failure together.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(sv_q && rf_q))
		else $error("sample_valid and read_failed both set");

	// Once set, the error flag stays set.
	assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared");

	// The serial clock is low while waiting for a scan or for data-ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE || phase_q == PH_WAIT) |-> !sck_q)
		else $error("serial clock high outside a transfer");

	// A good sample leaves the failure counter at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sv_q) |-> (fail_q == '0))
		else $error("failure counter not cleared by a good sample");
endmodule

// ===== hdl/bridge_adc_serial_reader.sv =====
// Serial readout sequencer for a 24-bit bridge converter. Each input item is
// one timer tick carrying the sampled level of the converter's data output;
// each tick gives exactly one result item with the serial clock level to
// drive, the held code and temperature, and the good-sample, failure and
// sticky error flags. The block takes one tick per clock cycle while its
// results are taken: a two-entry queue feeds the sequencer, which advances
// one step per tick, and an output register holds each result, so a tick is
// accepted while the previous result waits. A tick is stored in the queue
// and then stepped into the output register before its result is on the
// output. Configuration writes are meant for when no tick is in flight.
// Interval and half-period writes take effect at the next reload of the timer
// that uses them; the ready timeout, error limit and extra pulses act at once.
module bridge_adc_serial_reader #(
	parameter int DATA_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bas_pkg::CFG_DATA_W-1:0] cfg_data,
	bas_in_if.sink                        ticks,
	bas_out_if.source                     results
);
	import bas_pkg::*;

	bas_in_if q_ch ();

	// Front: accepts ticks into the queue.
	bas_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ticks),
		.rd     (q_ch.source)
	);

	// Back: steps the readout sequencer and registers the result.
	bas_seq #(
		.DATA_BITS (DATA_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ticks     (q_ch.sink),
		.results   (results)
	);
endmodule
